/* hdl/uer_pkg.sv */
// Shared types and constants for the ultrasonic echo ranger.
// Holds the phase and result-kind codes, register indexes and distance constants.
// No dependencies.
package uer_pkg;

  localparam int unsigned LIMIT_W = 18;
  localparam int unsigned CM_W    = 12;
  localparam int unsigned DIST_W  = 13;
  localparam int unsigned REM_W   = 14;
  localparam int unsigned CFG_A_W = 3;

  localparam logic [DIST_W-1:0] DIST_MAX   = 13'd8191;
  localparam logic [REM_W:0]    DIST_STEP  = 15'd349;
  localparam logic [REM_W:0]    DIST_DIV   = 15'd10000;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TRIG  = 3'd1,
    PH_RISE  = 3'd2,
    PH_FALL  = 3'd3,
    PH_PAUSE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_VALID  = 3'd1,
    KIND_RANGE  = 3'd2,
    KIND_NORISE = 3'd3,
    KIND_NOFALL = 3'd4
  } kind_t;

  typedef enum logic [CFG_A_W-1:0] {
    REG_RUN      = 3'd0,
    REG_TRIG     = 3'd1,
    REG_RISE_TO  = 3'd2,
    REG_FALL_TO  = 3'd3,
    REG_PAUSE    = 3'd4,
    REG_MIN_CM   = 3'd5,
    REG_MAX_CM   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic half_up;
  } dist_ctl_t;

endpackage

/* hdl/uer_dist.sv */
// Running echo distance tracker for the ultrasonic echo ranger.
// Keeps floor(half_width * 349 / 10000) up to date as the width counter advances.
// Depends on uer_pkg.
module uer_dist (
  input  logic                        clk,
  input  uer_pkg::dist_ctl_t          ctl,
  output logic [uer_pkg::DIST_W-1:0]  dist_cm
);

  logic [uer_pkg::REM_W-1:0]  rem_r;
  logic [uer_pkg::REM_W-1:0]  rem_nxt;
  logic [uer_pkg::DIST_W-1:0] dist_r;
  logic [uer_pkg::DIST_W-1:0] dist_nxt;
  logic [uer_pkg::REM_W:0]    rem_sum;

  always_comb begin
    rem_sum  = {1'b0, rem_r} + uer_pkg::DIST_STEP;
    rem_nxt  = rem_r;
    dist_nxt = dist_r;
    if (ctl.load) begin
      rem_nxt  = '0;
      dist_nxt = '0;
    end else if (ctl.step && ctl.half_up) begin
      if (rem_sum >= uer_pkg::DIST_DIV) begin
        rem_nxt = uer_pkg::REM_W'(rem_sum - uer_pkg::DIST_DIV);
        if (dist_r != uer_pkg::DIST_MAX) begin
          dist_nxt = dist_r + 1'b1;
        end
      end else begin
        rem_nxt = uer_pkg::REM_W'(rem_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dist_r <= dist_nxt;
  end

  assign dist_cm = dist_r;

endmodule

/* hdl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger top level: trigger/echo sequencer and output register.
// Depends on uer_pkg and uer_dist.
//
// Each input transaction is one timebase tick carrying the sampled echo level, and each
// tick yields exactly one output transaction in the next cycle with the trigger level, a
// result kind and a distance in centimeters. A tick is taken every clock cycle unless the
// output stalls; the single next-state pass of the phase sequencer sets that rate, and the
// distance is tracked incrementally while the echo is high so no multiply or divide sits in
// that pass. The input side keeps taking ticks while a result waits, as long as the output
// register is empty or is being drained in the same cycle.
module ultrasonic_echo_ranger #(
  parameter int unsigned COUNTER_BITS = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [uer_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [uer_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [0] echo_level
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [15:0]                  out_tdata,  // [0] trigger_level, [13:1] distance_cm
  output logic [2:0]                   out_tuser   // [2:0] result_kind
);

  localparam int unsigned CMP_W = (COUNTER_BITS > uer_pkg::LIMIT_W) ? COUNTER_BITS
                                                                   : uer_pkg::LIMIT_W;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  logic                         run_r;
  logic [uer_pkg::LIMIT_W-1:0]  trig_ticks_r;
  logic [uer_pkg::LIMIT_W-1:0]  rise_to_r;
  logic [uer_pkg::LIMIT_W-1:0]  fall_to_r;
  logic [uer_pkg::LIMIT_W-1:0]  pause_r;
  logic [uer_pkg::CM_W-1:0]     min_cm_r;
  logic [uer_pkg::CM_W-1:0]     max_cm_r;

  uer_pkg::phase_t              phase_r;
  uer_pkg::phase_t              phase_nxt;
  logic [COUNTER_BITS-1:0]      cnt_r;
  logic [COUNTER_BITS-1:0]      cnt_nxt;
  logic                         echo_prev_r;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic                         out_trig_r;
  uer_pkg::kind_t               out_kind_r;
  logic [uer_pkg::DIST_W-1:0]   out_dist_r;

  logic                         trig_c;
  uer_pkg::kind_t               kind_c;
  logic [uer_pkg::DIST_W-1:0]   dist_c;
  logic [uer_pkg::DIST_W-1:0]   track_cm;
  uer_pkg::dist_ctl_t           dctl;

  logic                         in_fire;
  logic                         echo;
  logic                         rise;
  logic                         fall;

  function automatic logic reached(input logic [COUNTER_BITS-1:0] c,
                                   input logic [uer_pkg::LIMIT_W-1:0] lim);
    reached = (CMP_W'(c) >= CMP_W'(lim)) || (c == CNT_MAX);
  endfunction

  function automatic logic [COUNTER_BITS-1:0] cnt_inc(input logic [COUNTER_BITS-1:0] c);
    cnt_inc = (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign echo      = in_tdata[0];
  assign rise      = echo && !echo_prev_r;
  assign fall      = !echo && echo_prev_r;

  uer_dist u_dist (
    .clk     (clk),
    .ctl     (dctl),
    .dist_cm (track_cm)
  );

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    trig_c    = 1'b0;
    kind_c    = uer_pkg::KIND_NONE;
    dist_c    = '0;
    dctl      = '0;
    if (!run_r) begin
      phase_nxt = uer_pkg::PH_IDLE;
      cnt_nxt   = '0;
    end else begin
      unique case (phase_r)
        uer_pkg::PH_IDLE: begin
          phase_nxt = uer_pkg::PH_TRIG;
          cnt_nxt   = '0;
        end
        uer_pkg::PH_PAUSE: begin
          if (reached(cnt_r, pause_r)) begin
            phase_nxt = uer_pkg::PH_TRIG;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_inc(cnt_r);
          end
        end
        uer_pkg::PH_RISE: begin
          if (rise) begin
            phase_nxt = uer_pkg::PH_FALL;
            cnt_nxt   = COUNTER_BITS'(1);
            dctl.load = 1'b1;
          end else begin
            cnt_nxt = cnt_inc(cnt_r);
            if (reached(cnt_nxt, rise_to_r)) begin
              kind_c    = uer_pkg::KIND_NORISE;
              phase_nxt = uer_pkg::PH_IDLE;
              cnt_nxt   = '0;
            end
          end
        end
        uer_pkg::PH_FALL: begin
          if (fall) begin
            dist_c    = track_cm;
            kind_c    = (track_cm > uer_pkg::DIST_W'(min_cm_r) &&
                         track_cm < uer_pkg::DIST_W'(max_cm_r)) ? uer_pkg::KIND_VALID
                                                                : uer_pkg::KIND_RANGE;
            phase_nxt = uer_pkg::PH_PAUSE;
            cnt_nxt   = '0;
          end else if (reached(cnt_r, fall_to_r)) begin
            kind_c    = uer_pkg::KIND_NOFALL;
            phase_nxt = uer_pkg::PH_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt      = cnt_inc(cnt_r);
            dctl.step    = 1'b1;
            dctl.half_up = cnt_r[0];
          end
        end
        uer_pkg::PH_TRIG: begin
        end
        default: begin
          phase_nxt = uer_pkg::PH_IDLE;
          cnt_nxt   = '0;
        end
      endcase

      if (phase_nxt == uer_pkg::PH_TRIG) begin
        trig_c  = 1'b1;
        cnt_nxt = cnt_inc(cnt_nxt);
        if (reached(cnt_nxt, trig_ticks_r)) begin
          phase_nxt = uer_pkg::PH_RISE;
          cnt_nxt   = '0;
        end
      end
    end
    if (!in_fire) begin
      dctl = '0;
    end
  end

  assign out_valid_nxt = in_fire || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r        <= 1'b0;
      trig_ticks_r <= 18'd1000;
      rise_to_r    <= 18'd10000;
      fall_to_r    <= 18'd190000;
      pause_r      <= 18'd1000;
      min_cm_r     <= 12'd4;
      max_cm_r     <= 12'd400;
      phase_r      <= uer_pkg::PH_IDLE;
      cnt_r        <= '0;
      echo_prev_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          uer_pkg::REG_RUN:     run_r        <= cfg_wdata[0];
          uer_pkg::REG_TRIG:    trig_ticks_r <= cfg_wdata;
          uer_pkg::REG_RISE_TO: rise_to_r    <= cfg_wdata;
          uer_pkg::REG_FALL_TO: fall_to_r    <= cfg_wdata;
          uer_pkg::REG_PAUSE:   pause_r      <= cfg_wdata;
          uer_pkg::REG_MIN_CM:  min_cm_r     <= cfg_wdata[uer_pkg::CM_W-1:0];
          uer_pkg::REG_MAX_CM:  max_cm_r     <= cfg_wdata[uer_pkg::CM_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        cnt_r       <= cnt_nxt;
        echo_prev_r <= echo;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_trig_r <= trig_c;
      out_kind_r <= kind_c;
      out_dist_r <= dist_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_dist_r, out_trig_r};
  assign out_tuser  = out_kind_r;

endmodule
